// File: sv/iss_pkg.sv
package iss_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // What a cell shows to both of its neighbors
    typedef struct packed {
        logic  valid;
        logic  greater;
        data_t data;
    } cell_link_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic  ins;
        logic  pop;
        data_t value;
    } cell_ctl_t;

endpackage

// File: sv/iss_stream_if.sv
interface iss_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   value;
    logic                 last_in;

    modport source(output valid, output value, output last_in, input ready);
    modport sink(input valid, input value, input last_in, output ready);
endinterface

interface iss_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   sorted_value;
    logic                 last_out;
    logic                 overflow;

    modport source(output valid, output sorted_value, output last_out, output overflow,
                   input ready);
    modport sink(input valid, input sorted_value, input last_out, input overflow,
                 output ready);
endinterface

// File: sv/iss_cell.sv
module iss_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  iss_pkg::cell_ctl_t  ctl,
    input  iss_pkg::cell_link_t left,
    input  iss_pkg::cell_link_t right,
    output iss_pkg::cell_link_t link
);

    logic           valid_reg;
    logic           valid_next;
    iss_pkg::data_t data_reg;
    iss_pkg::data_t data_next;
    logic           greater;

    // Strictly greater only: equal entries stay put, keeping the sort stable
    assign greater = valid_reg && (data_reg > ctl.value);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.ins)
        begin
            // Either shift up to make room, or take the free slot at the end
            if (greater || (!valid_reg && left.valid))
            begin
                valid_next = 1'b1;
                data_next  = left.greater ? left.data : ctl.value;
            end
        end
        else if (ctl.pop)
        begin
            // Advance toward the head while draining
            valid_next = right.valid;
            data_next  = right.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.valid   = valid_reg;
    assign link.greater = greater;
    assign link.data    = data_reg;

endmodule

// File: sv/insertion_sorter_core.sv
// Channel   Modport  Transaction
// in_ch     sink     value (signed Q16.16), last_in
// out_ch    source   sorted_value (signed Q16.16), last_out, overflow
//
// An input value is inserted into the row of cells as it is taken, so a batch
// streams in at one value per cycle. After the transaction with last_in, the
// row drains from its head at one result per cycle while out_ch.ready is high;
// in_ch.ready stays low until the final result is taken.
// Reset clears all cell valid bits, the drain flag and the overflow flag.
// A stall on out_ch holds the head result and the whole row.
module insertion_sorter_core (
    input logic       clk,
    input logic       rst_n,
    iss_in_if.sink    in_ch,
    iss_out_if.source out_ch
);

    iss_pkg::cell_ctl_t  ctl;
    iss_pkg::cell_link_t links [iss_pkg::CAPACITY];
    iss_pkg::cell_link_t head_link;
    iss_pkg::cell_link_t tail_link;

    logic draining_reg;
    logic draining_next;
    logic dropped_reg;
    logic dropped_next;
    logic in_take;
    logic out_take;
    logic full;

    assign full     = links[iss_pkg::CAPACITY-1].valid;
    assign in_take  = in_ch.valid && in_ch.ready;
    assign out_take = out_ch.valid && out_ch.ready;

    assign ctl.ins   = in_take && !full;
    assign ctl.pop   = out_take;
    assign ctl.value = in_ch.value;

    // The head cell sees an always-occupied, never-greater neighbor on its left
    assign head_link.valid   = 1'b1;
    assign head_link.greater = 1'b0;
    assign head_link.data    = '0;
    assign tail_link.valid   = 1'b0;
    assign tail_link.greater = 1'b0;
    assign tail_link.data    = '0;

    for (genvar i = 0; i < iss_pkg::CAPACITY; i++)
    begin : g_cell
        iss_pkg::cell_link_t left_link;
        iss_pkg::cell_link_t right_link;

        if (i == 0)
        begin : g_head
            assign left_link = head_link;
        end
        else
        begin : g_mid_left
            assign left_link = links[i-1];
        end

        if (i == iss_pkg::CAPACITY-1)
        begin : g_tail
            assign right_link = tail_link;
        end
        else
        begin : g_mid_right
            assign right_link = links[i+1];
        end

        iss_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .left  (left_link),
            .right (right_link),
            .link  (links[i])
        );
    end

    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        if (in_take)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (in_ch.last_in)
            begin
                draining_next = 1'b1;
            end
        end
        // Drop the batch state once the final result leaves
        if (out_take && !links[1].valid)
        begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign in_ch.ready         = !draining_reg;
    assign out_ch.valid        = draining_reg && links[0].valid;
    assign out_ch.sorted_value = links[0].data;
    assign out_ch.last_out     = !links[1].valid;
    assign out_ch.overflow     = dropped_reg;

endmodule

// File: tb/sv/iss_sort_checker.sv
module iss_sort_checker (
    input  logic clk,
    input  logic rst_n,
    iss_in_if    in_ch,
    iss_out_if   out_ch,
    output int   err_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        iss_pkg::data_t sorted_value;
        logic           last_out;
        logic           overflow;
    } sorted_result_t;

    iss_pkg::data_t batch_list[$];
    logic           batch_dropped = 1'b0;
    sorted_result_t sorted_q[$];
    int             fail_tally = 0;

    // Insert after every entry equal to v, so equal values keep arrival order
    function automatic void insert_sorted(input iss_pkg::data_t v);
        int pos;
        pos = batch_list.size();
        while (pos > 0 && batch_list[pos-1] > v)
            pos--;
        batch_list.insert(pos, v);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        sorted_result_t want;
        if (!rst_n)
        begin
            batch_list.delete();
            sorted_q.delete();
            batch_dropped = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (sorted_q.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("%0t: unexpected result value %0d last %0b overflow %0b",
                                 $realtime, out_ch.sorted_value, out_ch.last_out,
                                 out_ch.overflow);
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (out_ch.sorted_value !== want.sorted_value
                        || out_ch.last_out !== want.last_out
                        || out_ch.overflow !== want.overflow)
                    begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display({"%0t: mismatch: expected value %0d last %0b overflow %0b,",
                                      " got value %0d last %0b overflow %0b"},
                                     $realtime, want.sorted_value, want.last_out,
                                     want.overflow, out_ch.sorted_value, out_ch.last_out,
                                     out_ch.overflow);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                // Drop values once the list is full
                if (batch_list.size() >= iss_pkg::CAPACITY)
                    batch_dropped = 1'b1;
                else
                    insert_sorted(in_ch.value);
                if (in_ch.last_in)
                begin
                    foreach (batch_list[k])
                        sorted_q.push_back('{batch_list[k], k == batch_list.size() - 1,
                                             batch_dropped});
                    batch_list.delete();
                    batch_dropped = 1'b0;
                end
            end
        end
        err_count     <= fail_tally;
        pending_count <= sorted_q.size();
    end

endmodule

// File: tb/sv/tb_insertion_sorter_core.sv
module tb_insertion_sorter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             CYCLE_LIMIT  = 200000;
    localparam int             RANDOM_ITEMS = 196;
    localparam iss_pkg::data_t Q_MAX        = 32'sh7FFF_FFFF;
    localparam iss_pkg::data_t Q_MIN        = 32'sh8000_0000;
    localparam iss_pkg::data_t Q_ZERO       = 32'sh0000_0000;
    localparam iss_pkg::data_t Q_LSB_NEG    = 32'shFFFF_FFFF;
    localparam iss_pkg::data_t Q_LSB        = 32'sh0000_0001;
    localparam iss_pkg::data_t Q_HALF       = 32'sh0000_8000;
    localparam iss_pkg::data_t Q_HALF_NEG   = 32'shFFFF_8000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   err_count;
    int   pending_count;
    int   cycle_count = 0;
    bit   src_idle    = 1'b1;
    bit   snk_idle    = 1'b1;

    iss_in_if  in_ch();
    iss_out_if out_ch();

    insertion_sorter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    iss_sort_checker sort_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .err_count     (err_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic iss_pkg::data_t q16(input int whole);
        return iss_pkg::data_t'(whole <<< 16);
    endfunction

    function automatic iss_pkg::data_t pick_value();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return Q_ZERO;
                    default: return Q_LSB_NEG;
                endcase
            end
            1, 2:    return q16($urandom_range(0, 6) - 3);
            default: return iss_pkg::data_t'($urandom);
        endcase
    endfunction

    // Expects to be called right after a rising edge; returns at the accepting edge
    task automatic send_item(input iss_pkg::data_t v, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.last_in <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_batch(input iss_pkg::data_t vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_item(vals[i], i == vals.size() - 1);
    endtask

    // Result side: when snk_idle is set, hold ready low for a random stall before each transaction
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        iss_pkg::data_t batch[$];
        int             blen;
        int             sent;
        int             batch_idx;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.last_in = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-item batch, then extremes with duplicates and fractions
        batch = {Q_MAX};
        send_batch(batch);
        batch = {Q_MAX, Q_MIN, Q_ZERO, Q_LSB_NEG, Q_LSB, Q_MIN, Q_MAX, q16(1), Q_HALF,
                 Q_HALF_NEG};
        send_batch(batch);
        // Descending input shifts every entry; ascending shifts none
        batch = {q16(5), q16(4), q16(3), q16(2), q16(1)};
        send_batch(batch);
        batch = {q16(-2), q16(-1), q16(-1), q16(0), q16(2)};
        send_batch(batch);
        batch = {32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678};
        send_batch(batch);

        sent      = 0;
        batch_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            src_idle = $urandom_range(0, 3) != 0;
            snk_idle = $urandom_range(0, 3) != 0;
            // Force a batch that exactly fills the list at index 3 and one that overflows at index 7
            if (batch_idx == 3)
                blen = iss_pkg::CAPACITY;
            else if (batch_idx == 7)
                blen = iss_pkg::CAPACITY + 1;
            else if ($urandom_range(0, 9) == 0)
                blen = $urandom_range(iss_pkg::CAPACITY - 1, iss_pkg::CAPACITY + 6);
            else
                blen = $urandom_range(1, 10);
            batch.delete();
            repeat (blen) batch.push_back(pick_value());
            case ($urandom_range(0, 4))
                0:       batch.sort();
                1:       batch.rsort();
                default: ;
            endcase
            send_batch(batch);
            sent += blen;
            batch_idx++;
        end
        in_ch.valid <= 1'b0;

        // Let the checker register the final transaction before polling its count
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
